// ===== hw/rtl/tvs_pkg.sv =====
// Shared definitions for the tagged value stack: command and status codes,
// field widths and the default stack depth. No dependencies.
`default_nettype none

package tvs_pkg;

    localparam int STACK_DEPTH_DEF = 256;

    // Field widths of one stack entry and of the stream items.
    localparam int TAG_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int ENTRY_W   = TAG_W + PAYLOAD_W;
    localparam int CMD_W     = 3;
    localparam int TRUNC_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 10;
    localparam int SLOTS_W   = 9;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DROP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRUNC = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/tvs_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module tvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tagged_value_stack.sv =====
// Top level of the tagged value stack: command decode, stack pointer,
// result register. Depends on tvs_pkg and tvs_ram.
//
// A last-in first-out stack of tagged 64-bit words for an interpreter. Each
// input transfer carries one command (push, pop, peek, drop, truncate) and
// yields exactly one result transfer with the value read, a status and the
// entry count less the reserved local slots. The command is decoded and the
// stack memory is read in the accept cycle (state S_IDLE); in state S_RESP
// the memory's registered read data forms the result once the output
// register is free. The result sits in an output register; while it waits
// to be taken, the next item is still accepted and held only in S_RESP. No
// clearing pass is needed after reset.
`default_nettype none

module tagged_value_stack #(
    parameter int STACK_DEPTH = tvs_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration: local_slots.
    input  wire logic                            cfg_we,
    input  wire logic [tvs_pkg::SLOTS_W-1:0]     cfg_wdata,
    // Commands. tdata, low bit up: command, push_tag, push_payload, truncate_top.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tvs_pkg::IN_DATA_W-1:0]   s_tdata,
    // Results. tdata, low bit up: value_tag, value_payload, status, item_count.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [tvs_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > tvs_pkg::SLOTS_W) ? CNT_W : tvs_pkg::SLOTS_W;
    localparam int DIFF_W = CMP_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic signed [DIFF_W-1:0] SAT_HI = DIFF_W'(511);
    localparam logic signed [DIFF_W-1:0] SAT_LO = DIFF_W'(-512);

    typedef enum logic {S_IDLE, S_RESP} state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [tvs_pkg::SLOTS_W-1:0]     slots_reg;
    logic                            has_val_reg, has_val_next;
    logic [tvs_pkg::STATUS_W-1:0]    pend_status_reg, pend_status_next;
    logic [tvs_pkg::COUNT_W-1:0]     pend_count_reg, pend_count_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [tvs_pkg::TAG_W-1:0]       out_tag_reg, out_tag_next;
    logic [tvs_pkg::PAYLOAD_W-1:0]   out_payload_reg, out_payload_next;
    logic [tvs_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [tvs_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;

    logic [tvs_pkg::CMD_W-1:0]       cmd;
    logic [tvs_pkg::TAG_W-1:0]       push_tag;
    logic [tvs_pkg::PAYLOAD_W-1:0]   push_payload;
    logic [tvs_pkg::TRUNC_W-1:0]     truncate_top;
    logic                            accept;
    logic                            full;
    logic                            empty;
    logic [tvs_pkg::TRUNC_W-1:0]     trunc_lim;
    logic signed [DIFF_W-1:0]        diff;
    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [ADDR_W-1:0]               top_addr;
    logic [tvs_pkg::ENTRY_W-1:0]     rd_data;

    assign cmd          = s_tdata[2:0];
    assign push_tag     = s_tdata[6:3];
    assign push_payload = s_tdata[70:7];
    assign truncate_top = s_tdata[79:71];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);

    // Truncate keeps indexes up to truncate_top, so a larger count drops to
    // truncate_top + 1; anything below -1 empties the stack.
    assign trunc_lim = truncate_top[tvs_pkg::TRUNC_W-1] ? '0
                     : truncate_top + tvs_pkg::TRUNC_W'(1);

    assign wr_en    = accept && (cmd == tvs_pkg::CMD_PUSH) && !full;
    assign wr_addr  = count_reg[ADDR_W-1:0];
    assign top_addr = ADDR_W'(count_reg - CNT_W'(1));

    tvs_ram #(
        .WIDTH (tvs_pkg::ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({push_payload, push_tag}),
        .rd_en   (accept),
        .rd_addr (top_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next       = count_reg;
        has_val_next     = 1'b0;
        pend_status_next = tvs_pkg::ST_OK;
        unique case (cmd) inside
            tvs_pkg::CMD_PUSH:
            begin
                if (full)
                begin
                    pend_status_next = tvs_pkg::ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            tvs_pkg::CMD_POP, tvs_pkg::CMD_PEEK, tvs_pkg::CMD_DROP:
            begin
                if (empty)
                begin
                    pend_status_next = tvs_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    has_val_next = (cmd != tvs_pkg::CMD_DROP);
                    if (cmd != tvs_pkg::CMD_PEEK)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            tvs_pkg::CMD_TRUNC:
            begin
                if (CMP_W'(count_reg) > CMP_W'(trunc_lim))
                begin
                    count_next = CNT_W'(trunc_lim);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        diff = signed'({1'b0, CMP_W'(count_next)}) - signed'({1'b0, CMP_W'(slots_reg)});
        if (diff > SAT_HI)
        begin
            pend_count_next = SAT_HI[tvs_pkg::COUNT_W-1:0];
        end
        else if (diff < SAT_LO)
        begin
            pend_count_next = SAT_LO[tvs_pkg::COUNT_W-1:0];
        end
        else
        begin
            pend_count_next = diff[tvs_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_tag_next     = out_tag_reg;
        out_payload_next = out_payload_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // The memory read data holds until the next accept, so the
                // result can wait here for the output register to free up.
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next       = S_IDLE;
                    m_tvalid_next    = 1'b1;
                    out_tag_next     = has_val_reg ? rd_data[tvs_pkg::TAG_W-1:0] : '0;
                    out_payload_next = has_val_reg ? rd_data[tvs_pkg::ENTRY_W-1:tvs_pkg::TAG_W]
                                                   : '0;
                    out_status_next  = pend_status_reg;
                    out_count_next   = pend_count_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            slots_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
            out_tag_reg     <= '0;
            out_payload_reg <= '0;
            out_status_reg  <= '0;
            out_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            out_tag_reg     <= out_tag_next;
            out_payload_reg <= out_payload_next;
            out_status_reg  <= out_status_next;
            out_count_reg   <= out_count_next;
            if (cfg_we)
            begin
                slots_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            has_val_reg     <= has_val_next;
            pend_status_reg <= pend_status_next;
            pend_count_reg  <= pend_count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_count_reg, out_status_reg, out_payload_reg, out_tag_reg};

    // The stack pointer never passes the memory depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("stack count beyond depth");

    // A push that finds room grows the stack by exactly one entry.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd == tvs_pkg::CMD_PUSH) && !full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance the stack pointer");

    // An underflow result carries nil.
    a_underflow_nil: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && (out_status_reg == tvs_pkg::ST_UNDERFLOW)
        |-> (out_tag_reg == '0) && (out_payload_reg == '0))
        else $error("underflow result carries a value");

    // A second item is never taken while the first one is still being formed.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input accepted during result cycle");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tagged_value_stack: a queue-fed stream driver,
// a result monitor and a stack predictor. Depends on tvs_pkg and the RTL.

module testbench;
    import tvs_pkg::*;

    localparam int LONG_STALL = 80;
    // Command codes that the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]     op;
        logic [TAG_W-1:0]     tag;
        logic [PAYLOAD_W-1:0] payload;
        logic [TRUNC_W-1:0]   trunc_top;
    } stack_cmd_t;

    typedef struct {
        logic [TAG_W-1:0]     tag;
        logic [PAYLOAD_W-1:0] payload;
        logic [STATUS_W-1:0]  status;
        logic [COUNT_W-1:0]   count;
    } stack_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [SLOTS_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // tdata, low bit up: command, push_tag, push_payload, truncate_top.
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // tdata, low bit up: value_tag, value_payload, status, item_count.
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor state.
    logic [TAG_W-1:0]      tag_mem [STACK_DEPTH_DEF];
    logic [PAYLOAD_W-1:0]  payload_mem [STACK_DEPTH_DEF];
    int                    top_idx = -1;
    int                    slots = 0;

    stack_cmd_t            cmd_queue [$];
    stack_result_t         expected_results [$];
    stack_cmd_t            offered;
    int                    src_gap = 0;
    int                    sink_hold = 0;
    bit                    calm = 1'b0;
    bit                    stall_armed = 1'b0;
    bit                    stall_served = 1'b0;
    int                    err_count = 0;
    int                    gen_depth = 0;

    tagged_value_stack #(.STACK_DEPTH(STACK_DEPTH_DEF)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Applies one command to the predicted stack and returns its result.
    function automatic stack_result_t stack_step(input stack_cmd_t c);
        stack_result_t r;
        int t;
        int n;
        r.tag = '0;
        r.payload = '0;
        r.status = ST_OK;
        case (c.op)
            CMD_PUSH:
            begin
                if (top_idx + 1 < STACK_DEPTH_DEF)
                begin
                    top_idx++;
                    tag_mem[top_idx] = c.tag;
                    payload_mem[top_idx] = c.payload;
                end
                else
                    r.status = ST_OVERFLOW;
            end
            CMD_POP, CMD_PEEK, CMD_DROP:
            begin
                if (top_idx >= 0)
                begin
                    if (c.op != CMD_DROP)
                    begin
                        r.tag = tag_mem[top_idx];
                        r.payload = payload_mem[top_idx];
                    end
                    if (c.op != CMD_PEEK)
                    begin
                        tag_mem[top_idx] = '0;
                        top_idx--;
                    end
                end
                else
                    r.status = ST_UNDERFLOW;
            end
            CMD_TRUNC:
            begin
                t = $signed(c.trunc_top);
                if (t < -1)
                    t = -1;
                if (top_idx > t)
                    top_idx = t;
            end
            default: ;
        endcase
        n = top_idx + 1 - slots;
        if (n > 511)
            n = 511;
        if (n < -512)
            n = -512;
        r.count = n[COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_result(input logic [OUT_DATA_W-1:0] d);
        stack_result_t e;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result with none expected: %h", d));
            return;
        end
        e = expected_results.pop_front();
        if (d[3:0] !== e.tag)
            report_mismatch($sformatf("value_tag %h, expected %h", d[3:0], e.tag));
        if (d[67:4] !== e.payload)
            report_mismatch($sformatf("value_payload %h, expected %h", d[67:4], e.payload));
        if (d[69:68] !== e.status)
            report_mismatch($sformatf("status %h, expected %h", d[69:68], e.status));
        if (d[79:70] !== e.count)
            report_mismatch($sformatf("item_count %h, expected %h", d[79:70], e.count));
    endtask

    // Driver: offers queued commands, with random gaps between transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(stack_step(offered));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    offered = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {offered.trunc_top, offered.payload, offered.tag, offered.op};
                    if (!calm && $urandom_range(5) == 0)
                        src_gap = $urandom_range(9, 1);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks every result transfer and stalls the output at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_hold = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (stall_armed && !stall_served)
            begin
                stall_served = 1'b1;
                sink_hold = LONG_STALL;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(6) == 0)
            begin
                sink_hold = $urandom_range(8);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic add_cmd(input logic [CMD_W-1:0] op, input logic [TAG_W-1:0] tag,
                           input logic [PAYLOAD_W-1:0] payload, input int trunc);
        stack_cmd_t c;
        c.op = op;
        c.tag = tag;
        c.payload = payload;
        c.trunc_top = trunc[TRUNC_W-1:0];
        cmd_queue.push_back(c);
        // Rough depth tracking, only to aim truncate targets.
        case (op)
            CMD_PUSH: if (gen_depth < STACK_DEPTH_DEF) gen_depth++;
            CMD_POP, CMD_DROP: if (gen_depth > 0) gen_depth--;
            CMD_TRUNC:
            begin
                if (trunc < -1)
                    trunc = -1;
                if (gen_depth - 1 > trunc)
                    gen_depth = trunc + 1;
            end
            default: ;
        endcase
    endtask

    // One random command. During a climb only pushes and peeks are issued.
    task automatic add_random_cmd(input int push_pct, input bit climb);
        logic [PAYLOAD_W-1:0] payload;
        logic [CMD_W-1:0] op;
        int trunc;
        int k;
        payload = {$urandom, $urandom};
        k = $urandom_range(9);
        if (k == 0)
            payload = '0;
        else if (k == 1)
            payload = '1;
        trunc = $urandom_range(511) - 256;
        if ($urandom_range(99) < push_pct)
            op = CMD_PUSH;
        else if (climb)
            op = CMD_PEEK;
        else
        begin
            case ($urandom_range(9))
                0, 1, 2: op = CMD_POP;
                3, 4:    op = CMD_PEEK;
                5, 6:    op = CMD_DROP;
                7, 8:    op = CMD_TRUNC;
                default:
                begin
                    case ($urandom_range(2))
                        0:       op = CMD_RSVD_5;
                        1:       op = CMD_RSVD_6;
                        default: op = CMD_RSVD_7;
                    endcase
                end
            endcase
        end
        if (op == CMD_TRUNC)
        begin
            case ($urandom_range(9))
                0: trunc = -1;
                1: trunc = -int'($urandom_range(256, 2));
                2: trunc = (gen_depth <= 255) ? int'($urandom_range(255, gen_depth)) : 255;
                default: trunc = gen_depth - 1 - int'($urandom_range(gen_depth < 8 ? gen_depth : 8));
            endcase
        end
        add_cmd(op, 4'($urandom), payload, trunc);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_local_slots(input int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[SLOTS_W-1:0];
        slots = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: underflow on an empty stack, field extremes, every command,
        // truncation above the top, to the bottom and below -1.
        add_cmd(CMD_POP, 4'd15, '1, -1);
        add_cmd(CMD_PEEK, 4'd0, '0, 255);
        add_cmd(CMD_DROP, 4'd9, '1, -256);
        add_cmd(CMD_PUSH, 4'd0, '0, 0);
        add_cmd(CMD_PUSH, 4'd15, '1, -1);
        add_cmd(CMD_PEEK, 4'd0, '0, 0);
        add_cmd(CMD_POP, 4'd0, '0, 0);
        add_cmd(CMD_POP, 4'd0, '0, 0);
        add_cmd(CMD_DROP, 4'd0, '0, 0);
        add_cmd(CMD_PUSH, 4'd5, {$urandom, $urandom}, 0);
        add_cmd(CMD_PUSH, 4'd10, {$urandom, $urandom}, 0);
        add_cmd(CMD_PUSH, 4'd3, 64'h8000_0000_0000_0001, 0);
        add_cmd(CMD_TRUNC, 4'd0, '0, 255);
        add_cmd(CMD_DROP, 4'd0, '0, 0);
        add_cmd(CMD_PEEK, 4'd0, '0, 0);
        add_cmd(CMD_TRUNC, 4'd0, '0, 0);
        add_cmd(CMD_PEEK, 4'd0, '0, 0);
        add_cmd(CMD_TRUNC, 4'd0, '0, -256);
        add_cmd(CMD_PEEK, 4'd0, '0, 0);
        add_cmd(CMD_PUSH, 4'd7, {$urandom, $urandom}, 0);
        add_cmd(CMD_TRUNC, 4'd0, '0, -1);
        add_cmd(CMD_RSVD_5, 4'd15, '1, 255);
        add_cmd(CMD_RSVD_6, 4'd1, '0, -2);
        add_cmd(CMD_RSVD_7, 4'd8, {$urandom, $urandom}, 128);
        add_cmd(CMD_PUSH, 4'd12, {$urandom, $urandom}, 0);
        wait_drained();

        // All slots reserved; fill the stack past full while the output stalls.
        write_local_slots(256);
        for (int i = 0; i < 290; i++)
            add_random_cmd(96, 1'b1);
        stall_armed = 1'b1;
        for (int i = 0; i < 120; i++)
            add_random_cmd(35, 1'b0);
        wait_drained();

        write_local_slots($urandom_range(255, 1));
        for (int i = 0; i < 250; i++)
            add_random_cmd(45, 1'b0);
        wait_drained();

        write_local_slots(0);
        for (int i = 0; i < 180; i++)
            add_random_cmd(40, 1'b0);
        wait_drained();

        calm = 1'b1;
        for (int i = 0; i < 100; i++)
            add_random_cmd(40, 1'b0);
        wait_drained();

        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding at end of run");
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
